// ===== sv/srcs_pkg.sv =====
// Package for the sparse row/column sum accumulator: item kinds, table word
// layout, result record and the saturating 48-bit add.
// No dependencies; imported by the top level.
`default_nettype none

package srcs_pkg;

  // Default table dimensions.
  localparam int unsigned DEF_NUM_ROWS    = 1024;
  localparam int unsigned DEF_NUM_COLUMNS = 1024;
  localparam int unsigned DEF_NUM_PLANES  = 8;

  // Field widths of one input transfer.
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned PLANE_W = 3;
  localparam int unsigned VALUE_W = 32;

  // Sums are signed Q32.16; a table word is {saturation mark, sum}.
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned WORD_W = SUM_W + 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Item kinds carried in tuser.
  typedef enum logic [0:0] {
    KIND_ACCUM = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  // One result item, laid out as it leaves on the output tdata.
  typedef struct packed {
    logic             column_saturated;
    logic             row_saturated;
    logic [SUM_W-1:0] column_sum;
    logic [SUM_W-1:0] row_sum;
  } result_t;

  // Add a Q16.16 value into a table word, clamp to 48 bits, keep the mark sticky.
  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] word,
                                                input logic [VALUE_W-1:0] value);
    logic [SUM_W:0]      total;
    logic [WORD_W-1:0]   res;
    total = {word[SUM_W-1], word[SUM_W-1:0]}
          + {{(SUM_W+1-VALUE_W){value[VALUE_W-1]}}, value};
    if (total[SUM_W] != total[SUM_W-1]) begin
      res = {1'b1, (total[SUM_W] ? SUM_MIN : SUM_MAX)};
    end else begin
      res = {word[SUM_W], total[SUM_W-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/srcs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the row and column sum tables.
`default_nettype none

module srcs_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // A read in the cycle of a write to the same entry returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/sparse_row_column_sum_accumulator_top.sv =====
// Sparse row/column sum accumulator: scatter-adds into row and column sum memories.
// Depends on srcs_pkg and srcs_ram.
// Throughput: one transfer per cycle while in_tready is high; any mix of accumulates/reads.
// A read transfer's result passes stage one and the output queue before it is offered.
// Each table RAM has a registered read: read, saturating add, write back, with
// a one-entry bypass for an entry written in the previous cycle.
// Reset: synchronous, active low; afterwards a clearing pass over
// max(NUM_ROWS, NUM_COLUMNS) * NUM_PLANES entries (8192 by default) holds in_tready low.
`default_nettype none

module sparse_row_column_sum_accumulator_top #(
  parameter int unsigned NUM_ROWS    = srcs_pkg::DEF_NUM_ROWS,
  parameter int unsigned NUM_COLUMNS = srcs_pkg::DEF_NUM_COLUMNS,
  parameter int unsigned NUM_PLANES  = srcs_pkg::DEF_NUM_PLANES
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input stream.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: row_index[9:0], column_index[19:10], plane_index[22:20],
  //        entry_value[54:23], zero pad[55]
  input  wire logic [55:0]  in_tdata,
  // tuser: kind[0]
  input  wire logic [0:0]   in_tuser,
  // Result stream.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: row_sum[47:0], column_sum[95:48], row_saturated[96],
  //        column_saturated[97], zero pad[103:98]
  output logic [103:0]      out_tdata
);

  import srcs_pkg::*;

  localparam int unsigned ROW_DEPTH = NUM_ROWS * NUM_PLANES;
  localparam int unsigned COL_DEPTH = NUM_COLUMNS * NUM_PLANES;
  localparam int unsigned RAW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned CAW = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
  localparam int unsigned CLR_DEPTH = (ROW_DEPTH > COL_DEPTH) ? ROW_DEPTH : COL_DEPTH;
  localparam int unsigned CLW = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int unsigned RES_W = $bits(result_t);

  // Input field split.
  logic [INDEX_W-1:0] in_row;
  logic [INDEX_W-1:0] in_col;
  logic [PLANE_W-1:0] in_plane;
  logic [VALUE_W-1:0] in_value;
  kind_t              in_kind;

  assign in_row   = in_tdata[INDEX_W-1:0];
  assign in_col   = in_tdata[2*INDEX_W-1:INDEX_W];
  assign in_plane = in_tdata[2*INDEX_W+PLANE_W-1:2*INDEX_W];
  assign in_value = in_tdata[2*INDEX_W+PLANE_W+VALUE_W-1:2*INDEX_W+PLANE_W];
  assign in_kind  = kind_t'(in_tuser);

  // Range checks and table addresses (index * NUM_PLANES + plane).
  logic           in_plane_ok;
  logic           in_row_ok;
  logic           in_col_ok;
  logic [31:0]    in_raddr_full;
  logic [31:0]    in_caddr_full;
  logic [RAW-1:0] in_raddr;
  logic [CAW-1:0] in_caddr;

  assign in_plane_ok   = 32'(in_plane) < NUM_PLANES;
  assign in_row_ok     = in_plane_ok && (32'(in_row) < NUM_ROWS);
  assign in_col_ok     = in_plane_ok && (32'(in_col) < NUM_COLUMNS);
  assign in_raddr_full = 32'(in_row) * 32'(NUM_PLANES) + 32'(in_plane);
  assign in_caddr_full = 32'(in_col) * 32'(NUM_PLANES) + 32'(in_plane);
  assign in_raddr      = in_raddr_full[RAW-1:0];
  assign in_caddr      = in_caddr_full[CAW-1:0];

  logic in_accept;
  assign in_accept = in_tvalid && in_tready;

  // Clearing pass after reset.
  logic           clearing_r;
  logic [CLW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == CLW'(CLR_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Stage one: item whose table words are being read this cycle.
  logic               s1_valid_r;
  kind_t              s1_kind_r;
  logic               s1_row_ok_r;
  logic               s1_col_ok_r;
  logic [RAW-1:0]     s1_raddr_r;
  logic [CAW-1:0]     s1_caddr_r;
  logic [VALUE_W-1:0] s1_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r   <= in_kind;
      s1_row_ok_r <= in_row_ok;
      s1_col_ok_r <= in_col_ok;
      s1_raddr_r  <= in_raddr;
      s1_caddr_r  <= in_caddr;
      s1_value_r  <= in_value;
    end
  end

  // Table memories.
  logic              row_we;
  logic [RAW-1:0]    row_waddr;
  logic [WORD_W-1:0] row_wdata;
  logic [WORD_W-1:0] row_rdata;
  logic              col_we;
  logic [CAW-1:0]    col_waddr;
  logic [WORD_W-1:0] col_wdata;
  logic [WORD_W-1:0] col_rdata;

  srcs_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (ROW_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (in_raddr),
    .rdata (row_rdata)
  );

  srcs_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (COL_DEPTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (in_caddr),
    .rdata (col_rdata)
  );

  // Bypass registers: the word written in the previous cycle.
  logic              fwd_row_valid_r;
  logic [RAW-1:0]    fwd_row_addr_r;
  logic [WORD_W-1:0] fwd_row_data_r;
  logic              fwd_col_valid_r;
  logic [CAW-1:0]    fwd_col_addr_r;
  logic [WORD_W-1:0] fwd_col_data_r;

  // Current words of the stage-one item, taking the bypass where it hits.
  logic [WORD_W-1:0] row_cur;
  logic [WORD_W-1:0] col_cur;
  logic              s1_accum;
  logic              row_upd;
  logic              col_upd;

  assign row_cur  = (fwd_row_valid_r && fwd_row_addr_r == s1_raddr_r) ? fwd_row_data_r
                                                                       : row_rdata;
  assign col_cur  = (fwd_col_valid_r && fwd_col_addr_r == s1_caddr_r) ? fwd_col_data_r
                                                                       : col_rdata;
  assign s1_accum = s1_valid_r && (s1_kind_r == KIND_ACCUM);
  assign row_upd  = s1_accum && s1_row_ok_r;
  assign col_upd  = s1_accum && s1_col_ok_r;

  // Write ports: zeros during the clearing pass, updated sums afterwards.
  always_comb begin
    if (clearing_r) begin
      row_we    = 32'(clr_cnt_r) < ROW_DEPTH;
      row_waddr = RAW'(clr_cnt_r);
      row_wdata = '0;
      col_we    = 32'(clr_cnt_r) < COL_DEPTH;
      col_waddr = CAW'(clr_cnt_r);
      col_wdata = '0;
    end else begin
      row_we    = row_upd;
      row_waddr = s1_raddr_r;
      row_wdata = sat_add(row_cur, s1_value_r);
      col_we    = col_upd;
      col_waddr = s1_caddr_r;
      col_wdata = sat_add(col_cur, s1_value_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_row_valid_r <= 1'b0;
      fwd_col_valid_r <= 1'b0;
    end else begin
      fwd_row_valid_r <= row_we;
      fwd_col_valid_r <= col_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_row_addr_r <= row_waddr;
    fwd_row_data_r <= row_wdata;
    fwd_col_addr_r <= col_waddr;
    fwd_col_data_r <= col_wdata;
  end

  // Result of a read item.
  result_t s1_result;
  logic    push;

  always_comb begin
    s1_result.row_sum          = s1_row_ok_r ? row_cur[SUM_W-1:0] : '0;
    s1_result.row_saturated    = s1_row_ok_r && row_cur[SUM_W];
    s1_result.column_sum       = s1_col_ok_r ? col_cur[SUM_W-1:0] : '0;
    s1_result.column_saturated = s1_col_ok_r && col_cur[SUM_W];
  end

  assign push = s1_valid_r && (s1_kind_r == KIND_READ);

  // Two-entry output queue; input is taken only when a result slot is assured.
  result_t    out_q_r [2];
  logic       out_wr_ptr_r;
  logic       out_rd_ptr_r;
  logic [1:0] out_cnt_r;
  logic       pop;
  logic [2:0] occupancy;
  logic [2:0] room_limit;

  assign pop        = out_tvalid && out_tready;
  assign occupancy  = {1'b0, out_cnt_r} + {2'b00, push};
  assign room_limit = 3'd2 + {2'b00, pop};
  assign in_tready  = !clearing_r && (occupancy < room_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_ptr_r <= 1'b0;
      out_rd_ptr_r <= 1'b0;
      out_cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        out_wr_ptr_r <= ~out_wr_ptr_r;
      end
      if (pop) begin
        out_rd_ptr_r <= ~out_rd_ptr_r;
      end
      out_cnt_r <= out_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_q_r[out_wr_ptr_r] <= s1_result;
    end
  end

  assign out_tvalid = out_cnt_r != 2'd0;
  assign out_tdata  = {(104 - RES_W)'(0), out_q_r[out_rd_ptr_r]};

  // No item is taken while the tables are being cleared.
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("input transfer accepted during clearing pass");

  // An accepted read produces a queue push in the next cycle.
  a_read_pushes : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == KIND_READ) |=> push)
    else $error("read transfer did not produce a result");

  // The output queue never overflows.
  a_queue_room : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (out_cnt_r < 2'd2))
    else $error("result queue overflow");

  // The queue count stays within its two entries.
  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= 2'd2)
    else $error("result queue count out of range");

  // A row table update is only made by an accumulate accepted in the previous cycle.
  a_row_update_src : assert property (@(posedge clk) disable iff (!rst_n)
    (row_we && !clearing_r) |-> ($past(in_accept) && s1_kind_r == KIND_ACCUM))
    else $error("row table write without an accumulate item");

endmodule

`default_nettype wire
